@@ hdl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on a clock, disabled while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Default clock and reset names of this project.
`define ASSERT_STD(label, prop, msg) \
  `ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

@@ hdl/msdrs_pkg.sv @@
// ----------------------------------------------------------------------------
// msdrs_pkg
// Shared constants and a helper function of the radix key sorter.
// ----------------------------------------------------------------------------
package msdrs_pkg;

  localparam int unsigned Capacity   = 64;
  localparam int unsigned KeyBytes   = 8;
  localparam int unsigned BytesW     = 64;
  localparam int unsigned LenW       = 4;
  localparam int unsigned EntryW     = BytesW + LenW;
  localparam logic [LenW-1:0] MaxLen = 4'd8;

  typedef logic [EntryW-1:0] entry_t;

  // Saturates the length and zeroes the bytes past it.
  function automatic entry_t make_entry(logic [BytesW-1:0] bytes, logic [LenW-1:0] len);
    logic [LenW-1:0]   l;
    logic [BytesW-1:0] m;
    l = (len > MaxLen) ? MaxLen : len;
    m = ~({BytesW{1'b1}} >> {l, 3'b000});
    return {l, bytes & m};
  endfunction

endpackage

@@ hdl/msdrs_ram.sv @@
// ----------------------------------------------------------------------------
// msdrs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module msdrs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/msd_radix_key_sorter_core.sv @@
// ----------------------------------------------------------------------------
// msd_radix_key_sorter_core
// Collects a set of string keys and streams them back in ascending order.
// ----------------------------------------------------------------------------
// Keys load at one word per cycle until the word with tlast. The block then
// ranks every stored key against all n stored keys by sweeping the key RAM,
// places each key in the order RAM at its rank, and streams the set out word
// by word (read of the order RAM, output register load, handshake). The
// ranking sweep goes over the single read port of the key RAM. Input is
// refused from tlast until the last sorted word has been taken. Keys past
// the capacity are dropped and every output word of that set carries the
// overflow flag in tuser.
module msd_radix_key_sorter_core #(
  parameter int unsigned CAPACITY  = msdrs_pkg::Capacity,
  parameter int unsigned KEY_BYTES = msdrs_pkg::KeyBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [63:0] key_bytes, [67:64] key_length, [71:68] zero
  input  logic [71:0] s_axis_tdata_i,
  // last_key
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [63:0] sorted_bytes, [67:64] sorted_length, [71:68] zero
  output logic [71:0] m_axis_tdata_o,
  // last_out
  output logic        m_axis_tlast_o,
  // [0] overflow
  output logic        m_axis_tuser_o
);

  `include "assert_macros.svh"

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CapCnt = CW'(CAPACITY);
  localparam logic [msdrs_pkg::BytesW-1:0] CmpMask =
    ~({msdrs_pkg::BytesW{1'b1}} >> (8 * KEY_BYTES));
  localparam logic [msdrs_pkg::LenW-1:0] CmpLen = msdrs_pkg::LenW'(KEY_BYTES);

  typedef enum logic [2:0] {
    S_LOAD, S_FETCH, S_HOLD, S_SCAN, S_WRITE, S_ORD_RD, S_ORD_LD, S_ORD_WAIT
  } state_e;

  state_e state_q;
  logic [CW-1:0] n_q, i_q, j_q, rank_q, o_q;
  logic dropped_q, out_valid_q, out_last_q;
  msdrs_pkg::entry_t cur_q, out_data_q;

  logic key_we, ord_we;
  logic [AW-1:0] key_waddr, key_raddr, ord_waddr, ord_raddr;
  msdrs_pkg::entry_t key_wdata, key_rdata, ord_rdata;
  logic s_acc, m_acc, lower;

  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign m_acc = out_valid_q && m_axis_tready_i;

  // Ranking key: compared bytes, then length capped at the compared depth.
  function automatic logic [msdrs_pkg::EntryW-1:0] cmp_key(msdrs_pkg::entry_t e);
    logic [msdrs_pkg::LenW-1:0] l;
    l = e[msdrs_pkg::EntryW-1:msdrs_pkg::BytesW];
    if (l > CmpLen) l = CmpLen;
    return {e[msdrs_pkg::BytesW-1:0] & CmpMask, l};
  endfunction

  // Equal keys are split by load position, so every rank is unique.
  always_comb begin
    lower = (cmp_key(key_rdata) < cmp_key(cur_q)) ||
            ((cmp_key(key_rdata) == cmp_key(cur_q)) && (j_q < i_q));
  end

  always_comb begin
    key_we    = (state_q == S_LOAD) && s_acc && (n_q != CapCnt);
    key_waddr = n_q[AW-1:0];
    key_wdata = msdrs_pkg::make_entry(s_axis_tdata_i[63:0], s_axis_tdata_i[67:64]);
    key_raddr = i_q[AW-1:0];
    if (state_q == S_HOLD) key_raddr = '0;
    if (state_q == S_SCAN) key_raddr = AW'(j_q + 1'b1);
    ord_we    = (state_q == S_WRITE);
    ord_waddr = rank_q[AW-1:0];
    ord_raddr = o_q[AW-1:0];
  end

  msdrs_ram #(.Width(msdrs_pkg::EntryW), .Depth(CAPACITY)) u_key_ram (
    .clk_i, .we_i(key_we), .waddr_i(key_waddr), .wdata_i(key_wdata),
    .raddr_i(key_raddr), .rdata_o(key_rdata)
  );

  msdrs_ram #(.Width(msdrs_pkg::EntryW), .Depth(CAPACITY)) u_ord_ram (
    .clk_i, .we_i(ord_we), .waddr_i(ord_waddr), .wdata_i(cur_q),
    .raddr_i(ord_raddr), .rdata_o(ord_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      n_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      rank_q      <= '0;
      o_q         <= '0;
      dropped_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      cur_q       <= '0;
      out_data_q  <= '0;
    end else begin
      unique case (state_q)
        S_LOAD: begin
          if (s_acc) begin
            if (n_q == CapCnt) dropped_q <= 1'b1;
            else n_q <= n_q + 1'b1;
            if (s_axis_tlast_i) begin
              i_q     <= '0;
              state_q <= S_FETCH;
            end
          end
        end
        S_FETCH: state_q <= S_HOLD;
        S_HOLD: begin
          cur_q   <= key_rdata;
          j_q     <= '0;
          rank_q  <= '0;
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          if (lower) rank_q <= rank_q + 1'b1;
          j_q <= j_q + 1'b1;
          if (j_q == n_q - 1'b1) state_q <= S_WRITE;
        end
        S_WRITE: begin
          i_q <= i_q + 1'b1;
          if (i_q == n_q - 1'b1) begin
            o_q     <= '0;
            state_q <= S_ORD_RD;
          end else begin
            state_q <= S_FETCH;
          end
        end
        S_ORD_RD: state_q <= S_ORD_LD;
        S_ORD_LD: begin
          out_data_q  <= ord_rdata;
          out_last_q  <= (o_q == n_q - 1'b1);
          out_valid_q <= 1'b1;
          state_q     <= S_ORD_WAIT;
        end
        S_ORD_WAIT: begin
          if (m_acc) begin
            out_valid_q <= 1'b0;
            if (out_last_q) begin
              n_q       <= '0;
              dropped_q <= 1'b0;
              state_q   <= S_LOAD;
            end else begin
              o_q     <= o_q + 1'b1;
              state_q <= S_ORD_RD;
            end
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == S_LOAD);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, out_data_q};
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = dropped_q;

  `ASSERT_STD(a_count_cap, n_q <= CapCnt, "stored key count exceeds capacity")
  `ASSERT_STD(a_rank_range, (state_q == S_WRITE) |-> (rank_q < n_q), "rank out of range")
  `ASSERT_STD(a_no_overlap, !(s_axis_tready_o && out_valid_q), "load while output pending")
  `ASSERT_STD(a_set_nonempty, (state_q == S_FETCH) |-> (n_q != '0), "sorting an empty set")

endmodule
